@@ design/ipd_pkg.sv @@
// Shared types, codes and pattern tables for the IPD frame parser.
package ipd_pkg;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_COMMA   = 3'd1,
    PH_CHAN    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5
  } phase_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [15:0] CAP_RESET = 16'd1024;
  localparam logic [15:0] NUM_MAX   = 16'hFFFF;
  localparam logic [2:0]  PAT_LAST  = 3'd5;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  match_idx;
    logic        digit_seen;
    logic [15:0] chan_acc;
    logic [15:0] len_acc;
    logic [15:0] pay_cnt;
  } parse_state_t;

  typedef struct packed {
    status_t     status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] channel;
    logic [15:0] payload_len;
  } parse_result_t;

  localparam parse_state_t STATE_IDLE = '{
    phase: PH_PREFIX, match_idx: 3'd0, digit_seen: 1'b0,
    chan_acc: 16'd0, len_acc: 16'd0, pay_cnt: 16'd0
  };

  // CR LF '+' 'I' 'P' 'D'; index taken modulo six
  function automatic logic [7:0] head_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_CR;
      3'd1:    c = CH_LF;
      3'd2:    c = 8'h2B;
      3'd3:    c = 8'h49;
      3'd4:    c = 8'h50;
      3'd5:    c = 8'h44;
      3'd6:    c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

  // CR LF 'O' 'K' CR LF; index taken modulo six
  function automatic logic [7:0] tail_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_CR;
      3'd1:    c = CH_LF;
      3'd2:    c = 8'h4F;
      3'd3:    c = 8'h4B;
      3'd4:    c = CH_CR;
      3'd5:    c = CH_LF;
      3'd6:    c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

  // acc * 10 + d, saturating at 65535
  function automatic logic [15:0] add_digit(input logic [15:0] acc,
                                            input logic [3:0] d);
    logic [19:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
    return (v > {4'd0, NUM_MAX}) ? NUM_MAX : v[15:0];
  endfunction

endpackage

@@ design/ipd_step.sv @@
// Per-byte next-state and result logic of the IPD frame parser.
module ipd_step import ipd_pkg::*; (
  input  parse_state_t  cur,
  input  logic [7:0]    rx_byte,
  input  logic [15:0]   capacity,
  input  logic          limit_hit,
  output parse_state_t  nxt,
  output parse_result_t res
);

  parse_state_t upd;
  status_t      status;
  logic         pvalid;
  logic         is_digit;
  logic [3:0]   digit;
  logic [16:0]  cnt_inc;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit    = 4'(rx_byte - CH_ZERO);
  assign cnt_inc  = {1'b0, cur.pay_cnt} + 17'd1;

  always_comb begin
    upd    = cur;
    status = ST_BUSY;
    pvalid = 1'b0;
    if (limit_hit) begin
      status = ST_FULL;
    end else begin
      case (cur.phase)
        PH_PREFIX: begin
          if (rx_byte != head_char(cur.match_idx)) begin
            status = ST_BAD;
          end else if (cur.match_idx == PAT_LAST) begin
            upd.match_idx = 3'd0;
            upd.phase     = PH_COMMA;
          end else begin
            upd.match_idx = cur.match_idx + 3'd1;
          end
        end
        PH_COMMA: begin
          if (rx_byte != CH_COMMA) begin
            status = ST_BAD;
          end else begin
            upd.digit_seen = 1'b0;
            upd.phase      = PH_CHAN;
          end
        end
        PH_CHAN: begin
          if (is_digit) begin
            upd.chan_acc   = add_digit(cur.chan_acc, digit);
            upd.digit_seen = 1'b1;
          end else if (!cur.digit_seen || rx_byte != CH_COMMA) begin
            status = ST_BAD;
          end else begin
            upd.digit_seen = 1'b0;
            upd.phase      = PH_LEN;
          end
        end
        PH_LEN: begin
          if (is_digit) begin
            upd.len_acc    = add_digit(cur.len_acc, digit);
            upd.digit_seen = 1'b1;
          end else if (!cur.digit_seen || rx_byte != CH_COLON) begin
            status = ST_BAD;
          end else begin
            upd.digit_seen = 1'b0;
            upd.pay_cnt    = 16'd0;
            upd.match_idx  = 3'd0;
            upd.phase      = (cur.len_acc == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (cur.pay_cnt >= capacity) begin
            status = ST_BAD;
          end else begin
            pvalid      = 1'b1;
            upd.pay_cnt = cnt_inc[15:0];
            if (cnt_inc >= {1'b0, cur.len_acc}) begin
              upd.match_idx = 3'd0;
              upd.phase     = PH_TRAILER;
            end
          end
        end
        PH_TRAILER: begin
          if (rx_byte != tail_char(cur.match_idx)) begin
            status = ST_BAD;
          end else if (cur.match_idx == PAT_LAST) begin
            status = ST_DONE;
          end else begin
            upd.match_idx = cur.match_idx + 3'd1;
          end
        end
        default: status = ST_BAD;
      endcase
    end
  end

  // numbers are reported as they stand after this byte, before re-arm
  always_comb begin
    res.status        = status;
    res.payload_valid = pvalid;
    res.payload_byte  = pvalid ? rx_byte : 8'd0;
    res.channel       = upd.chan_acc;
    res.payload_len   = upd.len_acc;
    nxt               = (status != ST_BUSY) ? STATE_IDLE : upd;
  end

endmodule

@@ design/ipd_frame_parser_unit.sv @@
// Top level of the IPD frame parser: input register, parse step, result register.
// The input register feeds the step logic, whose result and updated parse state
// are registered together when the result slot is free. Throughput: one byte per
// cycle while the result slot is not held by out_stall.
// Reset (rst_n low, synchronous): both stages empty, parser re-armed at the
// prefix, payload capacity back to 1024. Payload registers are not reset.
module ipd_frame_parser_unit import ipd_pkg::*; #(
  parameter int unsigned FRAME_BYTE_LIMIT = 1056
) (
  input  logic        clk,
  input  logic        rst_n,
  // received byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // per-byte result
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_channel,
  output logic [15:0] out_payload_len,
  // capacity register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_payload_capacity
);

  // frame byte counter must reach the limit itself
  localparam int unsigned FCW = $clog2(FRAME_BYTE_LIMIT + 1);
  localparam logic [FCW-1:0] LIMIT = FCW'(FRAME_BYTE_LIMIT);

  logic           in_valid_r, in_valid_nxt;
  logic [7:0]     in_byte_r;
  logic           out_valid_r, out_valid_nxt;
  parse_result_t  res_r;
  parse_state_t   st_r;
  parse_state_t   st_nxt;
  parse_result_t  res_nxt;
  logic [FCW-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [15:0]    cap_r;
  logic           out_free;
  logic           take_in;
  logic           fire;
  logic           limit_hit;

  // result slot is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign take_in   = in_valid && !in_stall;
  assign limit_hit = (frame_cnt_r >= LIMIT);

  // user must write config only while idle, not enforced by the block; no back-pressure needed
  assign cfg_ready = 1'b1;

  ipd_step u_step (
    .cur       (st_r),
    .rx_byte   (in_byte_r),
    .capacity  (cap_r),
    .limit_hit (limit_hit),
    .nxt       (st_nxt),
    .res       (res_nxt)
  );

  always_comb begin
    in_valid_nxt = take_in ? 1'b1 : (fire ? 1'b0 : in_valid_r);
    out_valid_nxt = fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    // any terminal status re-arms, including a dropped byte at the limit
    if (res_nxt.status != ST_BUSY) begin
      frame_cnt_nxt = '0;
    end else begin
      frame_cnt_nxt = frame_cnt_r + FCW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_IDLE;
      frame_cnt_r <= '0;
      cap_r       <= CAP_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        st_r        <= st_nxt;
        frame_cnt_r <= frame_cnt_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_payload_capacity;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      in_byte_r <= in_rx_byte;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_payload_valid = res_r.payload_valid;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_channel       = res_r.channel;
  assign out_payload_len   = res_r.payload_len;

endmodule

@@ design/ipd_checker.sv @@
// Port-level assertions for the IPD frame parser, bound to the top level.
module ipd_checker import ipd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_payload_valid,
  input logic [7:0]  out_payload_byte,
  input logic [15:0] out_channel,
  input logic [15:0] out_payload_len
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_payload_byte) && $stable(out_channel))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_status == ST_BUSY && out_payload_len != 16'd0)
    else $error("payload byte with terminal status or zero length");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_byte == 8'd0)
    else $error("payload byte not cleared outside payload");

  // input is held back only by a stalled, full result slot
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result slot free");

endmodule

bind ipd_frame_parser_unit ipd_checker u_ipd_checker (.*);
